FILE: rtl/modular_inverse_ext_euclid_assert.svh
// assertion macros used by the checker mie_checker
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// clocked on i_clk, quiet while i_rst_n is low
`define MIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked on i_clk, checked during reset as well
`define MIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

FILE: rtl/mie_pkg.sv
`timescale 1ns / 1ps

package mie_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;

    typedef logic [FIELD_W-1:0] t_field;

endpackage

FILE: rtl/mie_if.sv
`timescale 1ns / 1ps

interface mie_in_if import mie_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field value;
    t_field modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mie_out_if import mie_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field inverse;
    t_field divisor;

    modport source (output valid, output inverse, output divisor, input ready);
    modport sink   (input valid, input inverse, input divisor, output ready);
endinterface

FILE: rtl/modular_inverse_ext_euclid.sv
// channel  dir  handshake        payload
// i_req    in   valid / ready    value, modulus
// o_rsp    out  valid / ready    inverse, divisor
//
// one request runs k euclid steps, plus the guard reduction when it is needed,
// and then holds its result until it is taken
// each euclid step runs the bit-serial restoring divider, one quotient bit a cycle
// reset is synchronous and clears the sequencer and the result valid
// i_req.ready is low from acceptance until the result has been taken
`timescale 1ns / 1ps

module modular_inverse_ext_euclid import mie_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mie_in_if.sink   i_req,
    mie_out_if.source o_rsp
);

    localparam int SW    = WIDTH + 1;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_FIX,
        S_MOD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    logic [WIDTH-1:0]   r_r0;
    logic [WIDTH-1:0]   r_r1;
    logic [SW-1:0]      r_s0;
    logic [SW-1:0]      r_s1;
    logic [WIDTH-1:0]   r_mod;
    logic [WIDTH-1:0]   r_inv;
    logic [WIDTH-1:0]   r_part;
    logic [WIDTH-1:0]   r_dvd;
    logic [WIDTH-1:0]   r_dvs;
    logic [SW-1:0]      r_acc;
    logic [CNT_W-1:0]   r_cnt;

    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;
    logic               qbit;
    logic [WIDTH-1:0]   n_part;
    logic [SW-1:0]      n_acc;
    logic [WIDTH-1:0]   inv_fix;
    logic               need_mod;
    logic               last_bit;

    // shared divider step, quotient bits fold straight into q*s1
    always_comb begin
        trial    = {r_part, r_dvd[WIDTH-1]};
        diff     = trial - {1'b0, r_dvs};
        qbit     = (trial >= {1'b0, r_dvs});
        n_part   = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        n_acc    = {r_acc[SW-2:0], 1'b0} + (qbit ? r_s1 : {SW{1'b0}});
        last_bit = (r_cnt == CNT_W'(WIDTH - 1));
        inv_fix  = r_s0[WIDTH-1:0] + (r_s0[WIDTH] ? r_mod : {WIDTH{1'b0}});
        need_mod = (r_mod != '0) && (inv_fix >= r_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_r0    <= WIDTH'(i_req.value);
                        r_r1    <= WIDTH'(i_req.modulus);
                        r_mod   <= WIDTH'(i_req.modulus);
                        r_s0    <= SW'(1);
                        r_s1    <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_r1 == '0) begin
                        r_state <= S_FIX;
                    end else begin
                        r_part  <= '0;
                        r_dvd   <= r_r0;
                        r_dvs   <= r_r1;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_part <= n_part;
                    r_acc  <= n_acc;
                    r_dvd  <= {r_dvd[WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (last_bit) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_r0    <= r_r1;
                    r_r1    <= r_part;
                    r_s0    <= r_s1;
                    r_s1    <= r_s0 - r_acc;
                    r_state <= S_CHECK;
                end
                S_FIX: begin
                    r_inv <= inv_fix;
                    if (need_mod) begin
                        r_part  <= '0;
                        r_dvd   <= inv_fix;
                        r_dvs   <= r_mod;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MOD;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_MOD: begin
                    r_part <= n_part;
                    r_acc  <= n_acc;
                    r_dvd  <= {r_dvd[WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (last_bit) begin
                        r_inv       <= n_part;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.inverse = FIELD_W'(r_inv);
    assign o_rsp.divisor = FIELD_W'(r_r0);

endmodule

FILE: rtl/mie_checker.sv
`timescale 1ns / 1ps
`include "modular_inverse_ext_euclid_assert.svh"

module mie_checker import mie_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_field i_inverse,
    input t_field i_divisor
);

    // one request in flight at a time
    `MIE_ASSERT(a_busy_after_req, i_in_valid && i_in_ready |=> !i_in_ready, "ready after request")
    `MIE_ASSERT(a_no_ready_with_rsp, i_out_valid |-> !i_in_ready, "ready while result waits")
    `MIE_ASSERT(a_ready_falls_on_req, $fell(i_in_ready) |-> $past(i_in_valid), "ready fell unasked")
    `MIE_ASSERT(a_rsp_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_inverse) && $stable(i_divisor), "result dropped or changed")
    `MIE_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_inverse   (o_rsp.inverse),
    .i_divisor   (o_rsp.divisor)
);

FILE: test/euclid_result_check.sv
`timescale 1ns / 1ps

module euclid_result_check import mie_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mie_in_if    i_req,
    mie_out_if   i_rsp,
    output int   o_failures,
    output int   o_outstanding
);

    typedef struct packed {
        t_field inverse;
        t_field divisor;
    } t_inverse_pair;

    t_inverse_pair awaited_q[$];
    int            failures = 0;
    int            checked  = 0;

    // extended euclid with the coefficient kept as 64-bit two's complement
    function automatic t_inverse_pair euclid_inverse(t_field value, t_field modulus);
        logic [63:0]   r_prev;
        logic [63:0]   r_cur;
        logic [63:0]   r_next;
        logic [63:0]   s_prev;
        logic [63:0]   s_cur;
        logic [63:0]   s_next;
        logic [63:0]   quot;
        logic [63:0]   coef;
        logic [63:0]   mod64;
        t_inverse_pair res;
        mod64  = 64'(modulus);
        r_prev = 64'(value);
        r_cur  = mod64;
        s_prev = 64'd1;
        s_cur  = 64'd0;
        while (r_cur != 64'd0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            s_next = s_prev - quot * s_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
        end
        coef = s_prev;
        if (coef[63]) begin
            coef = coef + mod64;
        end
        if (mod64 != 64'd0 && coef >= mod64) begin
            coef = coef % mod64;
        end
        res.inverse = coef[FIELD_W-1:0];
        res.divisor = r_prev[FIELD_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_inverse_pair want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_q.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result with no request pending: inverse %h divisor %h",
                                 $time, i_rsp.inverse, i_rsp.divisor);
                    end
                end else begin
                    want = awaited_q.pop_front();
                    checked++;
                    if (i_rsp.inverse !== want.inverse || i_rsp.divisor !== want.divisor) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: result %0d: inverse %h (exp %h) divisor %h (exp %h)",
                                     $time, checked, i_rsp.inverse, want.inverse,
                                     i_rsp.divisor, want.divisor);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_q.push_back(euclid_inverse(i_req.value, i_req.modulus));
            end
        end
        o_failures    <= failures;
        o_outstanding <= awaited_q.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mie_pkg::*;

    localparam int N_RANDOM   = 350;
    localparam int N_CALM     = 40;
    localparam int N_DIRECTED = 19;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;
    int   failures;
    int   outstanding;
    int   sent = 0;

    t_field dir_value [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_002A, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0003, 32'h0000_0007,
        32'h0000_0006, 32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFE, 32'd2971215073,
        32'd1836311903, 32'h0001_0001, 32'h0000_3039, 32'hAAAA_AAAA
    };
    t_field dir_modulus [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 32'hFFFF_FFFF, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0007, 32'h0000_0003,
        32'h0000_0009, 32'h0000_0002, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1836311903,
        32'd2971215073, 32'hFFFF_FFFB, 32'h0000_3039, 32'h5555_5555
    };

    mie_in_if  req_if ();
    mie_out_if rsp_if ();

    modular_inverse_ext_euclid dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    euclid_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side back-pressure
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            rsp_if.ready <= 1'b1;
            if (calm) begin
                @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(200, 600)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
                if (!calm) begin
                    rsp_if.ready <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge i_clk);
                end
            end
        end
    end

    task automatic put_request(input t_field value, input t_field modulus);
        req_if.valid   <= 1'b1;
        req_if.value   <= value;
        req_if.modulus <= modulus;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic sender_gap(input int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic pick_operands(output t_field value, output t_field modulus);
        t_field fib_lo;
        t_field fib_hi;
        t_field fib_sum;
        t_field factor;
        int     kind;
        kind    = $urandom_range(0, 11);
        value   = $urandom;
        modulus = $urandom;
        case (kind)
            4: begin
                modulus = $urandom_range(1, 255);
            end
            5: begin
                modulus = $urandom | 32'h1;
                value   = $urandom_range(0, modulus);
            end
            6: begin
                factor  = $urandom_range(2, 1000);
                value   = factor * $urandom_range(1, 1 << 20);
                modulus = factor * $urandom_range(1, 1 << 20);
            end
            7: begin
                fib_lo = 1;
                fib_hi = 1;
                repeat ($urandom_range(10, 45)) begin
                    fib_sum = fib_lo + fib_hi;
                    fib_lo  = fib_hi;
                    fib_hi  = fib_sum;
                end
                value   = $urandom_range(0, 1) ? fib_hi : fib_lo;
                modulus = (value == fib_hi) ? fib_lo : fib_hi;
            end
            8: begin
                case ($urandom_range(0, 5))
                    0: modulus = '0;
                    1: value = '0;
                    2: value = '1;
                    3: modulus = '1;
                    4: value = modulus;
                    default: value = 1;
                endcase
            end
            9: begin
                modulus = t_field'(1) << $urandom_range(0, 31);
            end
            10: begin
                value   = $urandom_range(0, 65535);
                modulus = $urandom_range(0, 65535);
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        t_field value;
        t_field modulus;
        req_if.valid   = 1'b0;
        req_if.value   = '0;
        req_if.modulus = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                sender_gap($urandom_range(1, 13));
            end
            put_request(dir_value[i], dir_modulus[i]);
        end
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                drain_results();
            end
            if (i == N_RANDOM - N_CALM) begin
                calm = 1'b1;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                sender_gap($urandom_range(1, 13));
            end
            pick_operands(value, modulus);
            put_request(value, modulus);
        end

        drain_results();
        repeat (2000) @(posedge i_clk);

        $display("tb: %0d requests sent (%0d fixed corner cases, rest random), %0d bad results",
                 sent, N_DIRECTED, failures);
        if (failures == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mie_pkg.sv
rtl/mie_if.sv
rtl/modular_inverse_ext_euclid.sv
rtl/mie_checker.sv
test/euclid_result_check.sv
test/testbench.sv
